// ----- rtl/core/lrer_pkg.sv -----
// shared types, codes and parse tables of the lr expression recognizer
`timescale 1ns / 1ps

package lrer_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF = 64;
    localparam int FIFO_DEPTH_DEF  = 2;

    localparam int NUM_STATES = 20;
    localparam int NUM_COLS   = 10;
    localparam int NUM_NTERMS = 3;
    localparam int NUM_RULES  = 11;

    // verdict codes
    localparam logic [1:0] VERDICT_PARSING = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT  = 2'd1;
    localparam logic [1:0] VERDICT_REJECT  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_CELL  = 2'd2;
    localparam logic [1:0] ERR_STACK = 2'd3;

    // token columns
    localparam logic [3:0] COL_ID     = 4'd0;
    localparam logic [3:0] COL_NUM    = 4'd1;
    localparam logic [3:0] COL_PLUS   = 4'd2;
    localparam logic [3:0] COL_MINUS  = 4'd3;
    localparam logic [3:0] COL_MUL    = 4'd4;
    localparam logic [3:0] COL_DIV    = 4'd5;
    localparam logic [3:0] COL_POW    = 4'd6;
    localparam logic [3:0] COL_LPAREN = 4'd7;
    localparam logic [3:0] COL_RPAREN = 4'd8;
    localparam logic [3:0] COL_END    = 4'd9;

    typedef enum logic [1:0] {
        ACT_ERR,
        ACT_SHIFT,
        ACT_REDUCE,
        ACT_ACCEPT
    } t_act;

    typedef enum logic [1:0] {
        TOK_SYM,
        TOK_SPACE,
        TOK_BAD
    } t_tok_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] error_kind;
        logic [4:0] top_state;
        logic [6:0] depth;
    } t_out;

    // classified character as seen by the parse engine
    typedef struct packed {
        logic       line_end;
        t_tok_kind  kind;
        logic [3:0] col;
    } t_tok;

    localparam t_act ACT_KIND [NUM_STATES][NUM_COLS] = '{
        '{ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_SHIFT, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_ERR, ACT_ERR},
        '{ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_SHIFT, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_ERR, ACT_ERR, ACT_ACCEPT},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_SHIFT,
          ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE,
          ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_SHIFT, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_ERR, ACT_ERR},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE,
          ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE,
          ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_ERR, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_ERR, ACT_ERR},
        '{ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_ERR, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_ERR, ACT_ERR},
        '{ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_ERR, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_ERR, ACT_ERR},
        '{ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_ERR, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_ERR, ACT_ERR},
        '{ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_ERR, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_ERR, ACT_ERR},
        '{ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_SHIFT, ACT_ERR,
          ACT_ERR, ACT_ERR, ACT_ERR, ACT_SHIFT, ACT_ERR},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_SHIFT,
          ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_SHIFT,
          ACT_SHIFT, ACT_SHIFT, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE,
          ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE,
          ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE,
          ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE,
          ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_REDUCE},
        '{ACT_ERR, ACT_ERR, ACT_REDUCE, ACT_REDUCE, ACT_REDUCE,
          ACT_REDUCE, ACT_REDUCE, ACT_ERR, ACT_REDUCE, ACT_REDUCE}
    };

    localparam logic [4:0] ACT_NUM [NUM_STATES][NUM_COLS] = '{
        '{5'd5, 5'd6, 5'd0, 5'd8, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd7, 5'd8, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd3, 5'd3, 5'd9, 5'd10, 5'd11, 5'd0, 5'd3, 5'd3},
        '{5'd0, 5'd0, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd0, 5'd7, 5'd7},
        '{5'd5, 5'd6, 5'd0, 5'd8, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd0, 5'd9, 5'd9},
        '{5'd0, 5'd0, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd0, 5'd10, 5'd10},
        '{5'd5, 5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0},
        '{5'd5, 5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0},
        '{5'd5, 5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0},
        '{5'd5, 5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0},
        '{5'd5, 5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd7, 5'd8, 5'd0, 5'd0, 5'd0, 5'd0, 5'd17, 5'd0},
        '{5'd0, 5'd0, 5'd1, 5'd1, 5'd9, 5'd10, 5'd11, 5'd0, 5'd1, 5'd1},
        '{5'd0, 5'd0, 5'd2, 5'd2, 5'd9, 5'd10, 5'd11, 5'd0, 5'd2, 5'd2},
        '{5'd0, 5'd0, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4, 5'd4},
        '{5'd0, 5'd0, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd0, 5'd5, 5'd5},
        '{5'd0, 5'd0, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd0, 5'd8, 5'd8},
        '{5'd0, 5'd0, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4, 5'd4},
        '{5'd0, 5'd0, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd0, 5'd11, 5'd11}
    };

    localparam logic [4:0] GOTO_STATE [NUM_STATES][NUM_NTERMS] = '{
        '{5'd1, 5'd2, 5'd3},   '{5'd14, 5'd2, 5'd3}, '{5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd0},   '{5'd12, 5'd2, 5'd3}, '{5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd13, 5'd3}, '{5'd19, 5'd14, 5'd3},
        '{5'd0, 5'd0, 5'd15},  '{5'd0, 5'd0, 5'd16}, '{5'd0, 5'd0, 5'd18},
        '{5'd19, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},
        '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0}
    };

    localparam logic [1:0] RULE_LEN [NUM_RULES] = '{
        2'd3, 2'd2, 2'd1, 2'd3, 2'd3, 2'd3, 2'd1, 2'd3, 2'd1, 2'd1, 2'd2
    };

    localparam logic [1:0] RULE_LHS [NUM_RULES] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2
    };

endpackage

// ----- rtl/core/lrer_fifo.sv -----
// small register fifo used between the front, the parse engine and the result port
`timescale 1ns / 1ps

module lrer_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = lrer_pkg::FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ----- rtl/core/lrer_front.sv -----
// character classifier: maps an input beat to a token column or a skip/bad code
`timescale 1ns / 1ps

module lrer_front (
    input  lrer_pkg::t_in  i_data,
    output lrer_pkg::t_tok o_tok
);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ID     = 8'h69;
    localparam logic [7:0] CH_NUM    = 8'h6E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    always_comb begin
        o_tok.line_end = i_data.line_end;
        o_tok.kind     = lrer_pkg::TOK_SYM;
        o_tok.col      = lrer_pkg::COL_END;
        if (!i_data.line_end) begin
            unique case (i_data.ch)
                CH_SPACE:  o_tok.kind = lrer_pkg::TOK_SPACE;
                CH_ID:     o_tok.col  = lrer_pkg::COL_ID;
                CH_NUM:    o_tok.col  = lrer_pkg::COL_NUM;
                CH_PLUS:   o_tok.col  = lrer_pkg::COL_PLUS;
                CH_MINUS:  o_tok.col  = lrer_pkg::COL_MINUS;
                CH_MUL:    o_tok.col  = lrer_pkg::COL_MUL;
                CH_DIV:    o_tok.col  = lrer_pkg::COL_DIV;
                CH_POW:    o_tok.col  = lrer_pkg::COL_POW;
                CH_LPAREN: o_tok.col  = lrer_pkg::COL_LPAREN;
                CH_RPAREN: o_tok.col  = lrer_pkg::COL_RPAREN;
                CH_DOLLAR: o_tok.col  = lrer_pkg::COL_END;
                default:   o_tok.kind = lrer_pkg::TOK_BAD;
            endcase
        end
    end

endmodule

// ----- rtl/core/lrer_back.sv -----
// parse engine: state stack memory, action/goto lookup and reduce loop
`timescale 1ns / 1ps

module lrer_back #(
    parameter int STACK_DEPTH = lrer_pkg::STACK_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lrer_pkg::t_tok i_tok,
    input  logic           i_tok_valid,
    output logic           o_tok_pop,
    output lrer_pkg::t_out o_res,
    output logic           o_res_push,
    input  logic           i_res_full
);

    localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW          = $clog2(STACK_DEPTH + 1);
    localparam int GUARD_LIMIT = 4 * STACK_DEPTH + 16;
    localparam int GW          = $clog2(GUARD_LIMIT + 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACT,
        ST_GOTO
    } t_state;

    t_state         r_state, n_state;
    logic [4:0]     r_top, n_top;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [1:0]     r_skip, n_skip;
    logic [GW-1:0]  r_guard, n_guard;
    logic [3:0]     r_col, n_col;
    logic [1:0]     r_lhs, n_lhs;
    logic           r_rd_zero, n_rd_zero;

    logic [4:0]     r_stack [STACK_DEPTH];
    logic [4:0]     r_rd;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [4:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;

    lrer_pkg::t_act kind;
    logic [4:0]     num;
    logic [3:0]     rule_idx;
    logic [1:0]     len;
    logic [CW-1:0]  pop_cnt;
    logic [4:0]     below;
    logic [4:0]     goto_top;
    logic           emit;
    logic [1:0]     verdict;
    logic [1:0]     err;

    always_comb begin
        kind      = lrer_pkg::ACT_KIND[r_top][r_col];
        num       = lrer_pkg::ACT_NUM[r_top][r_col];
        rule_idx  = 4'(num - 5'd1);
        len       = lrer_pkg::RULE_LEN[rule_idx];
        pop_cnt   = r_cnt - CW'(len);
        below     = r_rd_zero ? 5'd0 : r_rd;
        goto_top  = lrer_pkg::GOTO_STATE[below][r_lhs];

        n_state   = r_state;
        n_top     = r_top;
        n_cnt     = r_cnt;
        n_skip    = r_skip;
        n_guard   = r_guard;
        n_col     = r_col;
        n_lhs     = r_lhs;
        n_rd_zero = r_rd_zero;
        o_tok_pop = 1'b0;
        emit      = 1'b0;
        verdict   = lrer_pkg::VERDICT_PARSING;
        err       = lrer_pkg::ERR_NONE;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_cnt);
        mem_wdata = num;
        mem_raddr = AW'(pop_cnt - CW'(1));

        unique case (r_state)
            ST_IDLE: begin
                // only take a token when the result queue has room for its beat
                if (i_tok_valid && !i_res_full) begin
                    o_tok_pop = 1'b1;
                    if (!i_tok.line_end && r_skip != 2'd0) begin
                        // characters after an i or n token are dropped unchecked
                        n_skip = r_skip - 2'd1;
                        emit   = 1'b1;
                    end else begin
                        n_skip = 2'd0;
                        if (i_tok.kind == lrer_pkg::TOK_SPACE) begin
                            emit = 1'b1;
                        end else if (i_tok.kind == lrer_pkg::TOK_BAD) begin
                            emit = 1'b1;
                            err  = lrer_pkg::ERR_CHAR;
                        end else begin
                            n_col   = i_tok.col;
                            n_guard = '0;
                            n_state = ST_ACT;
                        end
                    end
                end
            end
            ST_ACT: begin
                if (r_top >= 5'(lrer_pkg::NUM_STATES) || r_guard > GW'(GUARD_LIMIT)) begin
                    emit = 1'b1;
                    err  = lrer_pkg::ERR_CELL;
                end else begin
                    unique case (kind)
                        lrer_pkg::ACT_SHIFT: begin
                            emit = 1'b1;
                            if (r_cnt >= CW'(STACK_DEPTH)) begin
                                err = lrer_pkg::ERR_STACK;
                            end else begin
                                mem_we = 1'b1;
                                n_cnt  = r_cnt + CW'(1);
                                n_top  = num;
                                if (r_col == lrer_pkg::COL_ID) begin
                                    n_skip = 2'd1;
                                end else if (r_col == lrer_pkg::COL_NUM) begin
                                    n_skip = 2'd2;
                                end
                            end
                        end
                        lrer_pkg::ACT_REDUCE: begin
                            if (num == 5'd0 || num > 5'(lrer_pkg::NUM_RULES)) begin
                                emit = 1'b1;
                                err  = lrer_pkg::ERR_CELL;
                            end else if (CW'(len) >= r_cnt) begin
                                emit = 1'b1;
                                err  = lrer_pkg::ERR_STACK;
                            end else begin
                                // entry zero is never written; a read of it is replaced by state 0 through r_rd_zero
                                n_cnt     = pop_cnt;
                                n_rd_zero = (pop_cnt == CW'(1));
                                n_lhs     = lrer_pkg::RULE_LHS[rule_idx];
                                n_guard   = r_guard + GW'(1);
                                n_state   = ST_GOTO;
                            end
                        end
                        lrer_pkg::ACT_ACCEPT: begin
                            emit    = 1'b1;
                            verdict = lrer_pkg::VERDICT_ACCEPT;
                        end
                        default: begin
                            emit = 1'b1;
                            err  = lrer_pkg::ERR_CELL;
                        end
                    endcase
                end
            end
            ST_GOTO: begin
                if (below >= 5'(lrer_pkg::NUM_STATES)) begin
                    emit = 1'b1;
                    err  = lrer_pkg::ERR_CELL;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = goto_top;
                    n_cnt     = r_cnt + CW'(1);
                    n_top     = goto_top;
                    n_state   = ST_ACT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (err != lrer_pkg::ERR_NONE) begin
            verdict = lrer_pkg::VERDICT_REJECT;
        end
        if (emit) begin
            n_state = ST_IDLE;
            if (verdict != lrer_pkg::VERDICT_PARSING) begin
                n_top  = 5'd0;
                n_cnt  = CW'(1);
                n_skip = 2'd0;
            end
        end

        o_res_push          = emit;
        o_res.verdict       = verdict;
        o_res.error_kind    = err;
        o_res.top_state     = n_top;
        o_res.depth         = 7'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_top     <= 5'd0;
            r_cnt     <= CW'(1);
            r_skip    <= 2'd0;
            r_guard   <= '0;
            r_col     <= lrer_pkg::COL_END;
            r_lhs     <= 2'd0;
            r_rd_zero <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_cnt     <= n_cnt;
            r_skip    <= n_skip;
            r_guard   <= n_guard;
            r_col     <= n_col;
            r_lhs     <= n_lhs;
            r_rd_zero <= n_rd_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_stack[mem_raddr];
    end

endmodule

// ----- rtl/core/lr_expression_recognizer_core.sv -----
// top level of the lr expression recognizer: classifier, token queue, parse engine
// path: dropped, space and bad characters go through the token queue and straight to the result
//   queue; a token also passes the ACT state and, per reduction, the GOTO state
// throughput: one dropped or space character per cycle while the result queue has room; a token
//   holds the parse engine, which takes no new token meanwhile, with a stack read and a goto push per reduction
// reset: synchronous, active low; queues empty, stack back to the single state-0 entry,
//   no clearing pass (entry zero is never written, other entries are written before use)
`timescale 1ns / 1ps

module lr_expression_recognizer_core #(
    parameter int STACK_DEPTH = lrer_pkg::STACK_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input side: one character beat per push
    input  logic           push,
    output logic           full,
    input  lrer_pkg::t_in  i_data,
    // result side: one result beat per input beat
    output logic           empty,
    input  logic           pop,
    output lrer_pkg::t_out o_data
);

    localparam int TOK_W = $bits(lrer_pkg::t_tok);
    localparam int RES_W = $bits(lrer_pkg::t_out);

    lrer_pkg::t_tok front_tok;   // classified beat entering the token queue
    lrer_pkg::t_tok queued_tok;  // oldest token waiting for the parse engine
    logic           tok_empty;
    logic           tok_pop;
    lrer_pkg::t_out res;
    logic           res_push;
    logic           res_full;

    // front: classify the character as it is accepted
    lrer_front u_front (
        .i_data (i_data),
        .o_tok  (front_tok)
    );

    // token queue decouples the front from the parse engine
    lrer_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (lrer_pkg::FIFO_DEPTH_DEF)
    ) u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_tok),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_rdata (queued_tok),
        .o_empty (tok_empty)
    );

    // back: shift/reduce engine with the state stack
    lrer_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (queued_tok),
        .i_tok_valid (!tok_empty),
        .o_tok_pop   (tok_pop),
        .o_res       (res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // result queue lets the engine run on while a result beat waits for pop
    lrer_fifo #(
        .WIDTH (RES_W),
        .DEPTH (lrer_pkg::FIFO_DEPTH_DEF)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (o_data),
        .o_empty (empty)
    );

endmodule

// ----- rtl/core/lrer_checker.sv -----
// port-level checks of the lr expression recognizer and their bind
`timescale 1ns / 1ps

module lrer_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           empty,
    input lrer_pkg::t_out o_data
);

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // an error code comes with a reject and only then
    a_err_matches_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_data.error_kind != lrer_pkg::ERR_NONE) ==
                    (o_data.verdict == lrer_pkg::VERDICT_REJECT)))
        else $error("error kind and verdict disagree");

    // a verdict restarts the stack
    a_verdict_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_data.verdict != lrer_pkg::VERDICT_PARSING |->
            o_data.top_state == 5'd0 && o_data.depth == 7'd1)
        else $error("stack not restarted after verdict");

    // parser state always in the table, verdict code always a known one
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_data.top_state < 5'(lrer_pkg::NUM_STATES)
            && o_data.verdict <= lrer_pkg::VERDICT_REJECT)
        else $error("bad state or verdict code on result");

endmodule

bind lr_expression_recognizer_core lrer_checker u_lrer_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .o_data  (o_data)
);
